// ----- rtl/hbnlt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbnlt_pkg: shared types and constants of the node liveness table
// Item kind codes, field widths, and the token, insert and result records
// that travel between the table cells and the top level.
// ----------------------------------------------------------------------------
package hbnlt_pkg;

   localparam int MAX_NODES_DEFAULT = 16;

   localparam int ADDR_W  = 16;
   localparam int TIME_W  = 63;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(1000000);

   localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SWEEP     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd2;

   // Item moving down the cell chain, one cell per cycle
   typedef struct packed {
      logic              active;
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] now;
      logic              found;      // a valid cell held this address
      logic              free_seen;  // a free cell was passed
   } hbnlt_token_type;

   // New entry written into the chosen free cell at the end of a heartbeat
   typedef struct packed {
      logic              active;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] now;
   } hbnlt_insert_type;

   // One result item
   typedef struct packed {
      logic               reachable;
      logic               node_added;
      logic               dropped_full;
      logic [COUNT_W-1:0] removed_count;
      logic [COUNT_W-1:0] node_count;
   } hbnlt_result_type;

endpackage

// ----- rtl/hbnlt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbnlt_cell: one slot of the node liveness table
// Holds one entry (valid, address, last seen time). When the item reaches
// the cell it matches, refreshes or ages out the entry, adds to the running
// counts and hands the item on to the next cell through its hand-off register.
// ----------------------------------------------------------------------------
module hbnlt_cell
   import hbnlt_pkg::*;
#(
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5,
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TIME_W-1:0]      timeout,
   input  hbnlt_token_type        tok_i,
   input  logic [IDX_W-1:0]       free_idx_i,
   input  logic [CNT_W-1:0]       valid_cnt_i,
   input  logic [CNT_W-1:0]       removed_i,
   input  hbnlt_insert_type       ins_i,
   input  logic [IDX_W-1:0]       ins_idx_i,
   output hbnlt_token_type        tok_o,
   output logic [IDX_W-1:0]       free_idx_o,
   output logic [CNT_W-1:0]       valid_cnt_o,
   output logic [CNT_W-1:0]       removed_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   // Entry storage
   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TIME_W-1:0] seen_ff, seen_in;

   // Item hand-off registers
   hbnlt_token_type   tok_ff, tok_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  valid_cnt_ff, valid_cnt_in;
   logic [CNT_W-1:0]  removed_ff, removed_in;

   logic              hit;
   logic              expire;
   logic [TIME_W:0]   age;

   // Age check: no borrow means time did not go backwards
   assign age    = {1'b0, tok_i.now} - {1'b0, seen_ff};
   assign hit    = valid_ff && (addr_ff == tok_i.addr);
   assign expire = valid_ff && !age[TIME_W] && (age[TIME_W-1:0] > timeout);

   // Cell update and hand-off
   always_comb begin
      valid_in     = valid_ff;
      addr_in      = addr_ff;
      seen_in      = seen_ff;
      tok_in       = tok_i;
      free_idx_in  = free_idx_i;
      valid_cnt_in = valid_cnt_i;
      removed_in   = removed_i;

      if (tok_i.active) begin
         unique case (tok_i.kind)
            KIND_HEARTBEAT: begin
               if (hit) begin
                  seen_in      = tok_i.now;
                  tok_in.found = 1'b1;
               end
            end
            KIND_SWEEP: begin
               if (expire) begin
                  valid_in   = 1'b0;
                  removed_in = removed_i + CNT_W'(1);
               end
            end
            KIND_QUERY: begin
               if (hit) begin
                  tok_in.found = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // lowest free slot seen so far
         if (!valid_ff && !tok_i.free_seen) begin
            tok_in.free_seen = 1'b1;
            free_idx_in      = MY_IDX;
         end

         valid_cnt_in = valid_cnt_i + CNT_W'(valid_in);
      end

      // insertion from the end of the chain
      if (ins_i.active && (ins_idx_i == MY_IDX)) begin
         valid_in = 1'b1;
         addr_in  = ins_i.addr;
         seen_in  = ins_i.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         tok_ff.active <= tok_in.active;
      end
      addr_ff          <= addr_in;
      seen_ff          <= seen_in;
      tok_ff.kind      <= tok_in.kind;
      tok_ff.addr      <= tok_in.addr;
      tok_ff.now       <= tok_in.now;
      tok_ff.found     <= tok_in.found;
      tok_ff.free_seen <= tok_in.free_seen;
      free_idx_ff      <= free_idx_in;
      valid_cnt_ff     <= valid_cnt_in;
      removed_ff       <= removed_in;
   end

   assign tok_o       = tok_ff;
   assign free_idx_o  = free_idx_ff;
   assign valid_cnt_o = valid_cnt_ff;
   assign removed_o   = removed_ff;

endmodule

// ----- rtl/heartbeat_node_liveness_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_node_liveness_table: table of known nodes with aging
// Chain of MAX_NODES cells; each item walks the chain and produces one
// result item.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one item per handshake: heartbeat (refresh or insert a node),
//    sweep (remove entries older than the timeout) or query (is the node
//    present). req_current_time is the present time stamp.
//  - rsp_*: one result item per request item, in order.
//  - csr_*: writes the timeout; always ready. Write only while idle.
//  - Chain walk: an item visits one cell per cycle, the first cell in the
//    cycle it is accepted; its result is formed at the end of the chain
//    and then registered. The walk through the chain limits intake: a new
//    item is taken only once the previous item has left the chain.
//  - The result sits in an output register with one spare register behind
//    it: a new item is taken while a result waits. The block takes no
//    items while both registers are full or while an item is in the chain.
//  - Reset empties the table and loads the timeout with 1000000.
// ----------------------------------------------------------------------------
module heartbeat_node_liveness_table
   import hbnlt_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request items
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ADDR_W-1:0]   req_node_address,
   input  logic [TIME_W-1:0]   req_current_time,
   // result items
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_reachable,
   output logic                rsp_node_added,
   output logic                rsp_dropped_full,
   output logic [COUNT_W-1:0]  rsp_removed_count,
   output logic [COUNT_W-1:0]  rsp_node_count,
   // timeout register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [TIME_W-1:0]   csr_timeout_interval
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);

   // Timeout register
   logic [TIME_W-1:0] timeout_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_timeout_interval;
      end
   end

   // Chain wiring
   hbnlt_token_type  tok_w       [MAX_NODES+1];
   logic [IDX_W-1:0] free_idx_w  [MAX_NODES+1];
   logic [CNT_W-1:0] valid_cnt_w [MAX_NODES+1];
   logic [CNT_W-1:0] removed_w   [MAX_NODES+1];
   hbnlt_insert_type ins;
   logic [IDX_W-1:0] ins_idx;

   logic busy_ff, busy_in;
   logic accept;
   logic fin;

   assign accept = req_valid && req_ready;

   // Item enters the first cell
   always_comb begin
      tok_w[0].active    = accept;
      tok_w[0].kind      = req_kind;
      tok_w[0].addr      = req_node_address;
      tok_w[0].now       = req_current_time;
      tok_w[0].found     = 1'b0;
      tok_w[0].free_seen = 1'b0;
      free_idx_w[0]      = '0;
      valid_cnt_w[0]     = '0;
      removed_w[0]       = '0;
   end

   for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_cell
      hbnlt_cell #(
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W),
         .CELL_IDX (gi)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .timeout     (timeout_ff),
         .tok_i       (tok_w[gi]),
         .free_idx_i  (free_idx_w[gi]),
         .valid_cnt_i (valid_cnt_w[gi]),
         .removed_i   (removed_w[gi]),
         .ins_i       (ins),
         .ins_idx_i   (ins_idx),
         .tok_o       (tok_w[gi+1]),
         .free_idx_o  (free_idx_w[gi+1]),
         .valid_cnt_o (valid_cnt_w[gi+1]),
         .removed_o   (removed_w[gi+1])
      );
   end

   // End of chain: form the result and the insertion
   hbnlt_token_type  last_tok;
   hbnlt_result_type res_new;
   logic             is_hb;
   logic             add_node;

   assign last_tok = tok_w[MAX_NODES];
   assign fin      = last_tok.active;
   assign is_hb    = (last_tok.kind == KIND_HEARTBEAT);
   assign add_node = is_hb && !last_tok.found && last_tok.free_seen;

   always_comb begin
      res_new.reachable     = (last_tok.kind == KIND_QUERY) && last_tok.found;
      res_new.node_added    = add_node;
      res_new.dropped_full  = is_hb && !last_tok.found && !last_tok.free_seen;
      res_new.removed_count = (last_tok.kind == KIND_SWEEP) ?
                              COUNT_W'(removed_w[MAX_NODES]) : '0;
      res_new.node_count    = COUNT_W'(valid_cnt_w[MAX_NODES] + CNT_W'(add_node));
      ins.active            = fin && add_node;
      ins.addr              = last_tok.addr;
      ins.now               = last_tok.now;
      ins_idx               = free_idx_w[MAX_NODES];
   end

   // Busy while an item is in the chain
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (fin) begin
         busy_in = 1'b0;
      end
   end

   // Output register plus one spare
   hbnlt_result_type rsp_ff, rsp_in;
   hbnlt_result_type pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy_ff && !pend_valid_ff;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (rsp_free) begin
         if (pend_valid_ff) begin
            rsp_in        = pend_ff;
            rsp_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (fin) begin
            rsp_in       = res_new;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (fin) begin
         pend_in       = res_new;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reachable     = rsp_ff.reachable;
   assign rsp_node_added    = rsp_ff.node_added;
   assign rsp_dropped_full  = rsp_ff.dropped_full;
   assign rsp_removed_count = rsp_ff.removed_count;
   assign rsp_node_count    = rsp_ff.node_count;

endmodule
